[hdl/srfc_pkg.sv]
// Shared types and constants of the servo reply frame checker.
package srfc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] status_t;
	typedef logic [2:0] pidx_t;
	typedef logic [3:0] pcount_t;

	// Result status codes
	localparam status_t STATUS_OK        = 3'd0;
	localparam status_t STATUS_SHORT     = 3'd1;
	localparam status_t STATUS_BAD_HDR   = 3'd2;
	localparam status_t STATUS_WRONG_ID  = 3'd3;
	localparam status_t STATUS_BAD_CHK   = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID          = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PARAM_COUNT = 1'd1;
	localparam int CFG_DATA_W = 8;

	// Frame layout: FF FF ID LEN ERR params CHK
	localparam byte_t HDR_BYTE = 8'hFF;
	localparam int    HDR_LEN  = 5;
	localparam int    SYNC_LEN = 2;
	localparam int    ID_POS   = 2;

	// Reset values of the configuration registers
	localparam byte_t   EXPECTED_ID_RST    = 8'd1;
	localparam pcount_t PARAM_COUNT_RST    = 4'd2;

endpackage

[hdl/srfc_if.sv]
// Valid/ready channel interfaces for received bytes and frame results.
interface srfc_rx_if;
	logic                  valid;
	logic                  ready;
	srfc_pkg::byte_t       rx_byte;
	logic                  timeout;

	modport source (output valid, output rx_byte, output timeout, input ready);
	modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface srfc_result_if;
	logic                  valid;
	logic                  ready;
	srfc_pkg::byte_t       param_byte;
	srfc_pkg::pidx_t       param_index;
	srfc_pkg::status_t     status;
	logic                  last;

	modport source (output valid, output param_byte, output param_index, output status,
		output last, input ready);
	modport sink   (input valid, input param_byte, input param_index, input status,
		input last, output ready);
endinterface

[hdl/servo_reply_frame_checker.sv]
// Servo reply frame checker: header/id/checksum check and parameter buffering.
//
//  channel  | dir | payload                                  | transfer when
//  rx       | in  | rx_byte, timeout                          | valid & ready
//  result   | out | param_byte, param_index, status, last     | valid & ready
//  cfg      | in  | cfg_index, cfg_data                       | cfg_we
//
// rx is held off during a parameter burst and while a result waits in the output
// register. On a good checksum byte with a nonzero parameter count the parameters
// are read back from the parameter memory, each through the registered read port
// and then the output register; the next read starts only once the output register is free.
// Reset clears the frame state and resets the config; the parameter memory is not cleared.
module servo_reply_frame_checker #(
	parameter int MAX_PARAMS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	srfc_rx_if.sink                           rx,
	srfc_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [srfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int POS_W = $clog2(MAX_PARAMS + 6);
	localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	srfc_pkg::byte_t     expected_id_q;
	srfc_pkg::pcount_t   expected_param_count_q;

	logic [POS_W-1:0]    pos_q;
	srfc_pkg::byte_t     running_sum_q;
	logic                header_bad_q;
	logic                id_bad_q;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    rd_idx_q;

	srfc_pkg::byte_t     param_mem [MAX_PARAMS];
	srfc_pkg::byte_t     mem_rdata_q;

	logic                out_valid_q;
	srfc_pkg::byte_t     out_byte_q;
	srfc_pkg::pidx_t     out_idx_q;
	srfc_pkg::status_t   out_status_q;
	logic                out_last_q;

	logic [POS_W-1:0]    n_eff;
	logic [POS_W-1:0]    chk_pos;
	logic                out_free;
	logic                in_xfer;
	logic                is_chk;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic                rd_last;

	logic                ld_en;
	srfc_pkg::byte_t     ld_byte;
	srfc_pkg::pidx_t     ld_idx;
	srfc_pkg::status_t   ld_status;
	logic                ld_last;
	logic                start_burst;

	// Clamp the parameter count and locate the checksum byte
	assign n_eff   = (32'(expected_param_count_q) > MAX_PARAMS) ? POS_W'(MAX_PARAMS)
		: POS_W'(expected_param_count_q);
	assign chk_pos = n_eff + POS_W'(srfc_pkg::HDR_LEN);

	assign out_free = !out_valid_q || result.ready;
	assign rx.ready = (state_q == ST_RUN) && out_free;
	assign in_xfer  = rx.valid && rx.ready;
	assign is_chk   = !rx.timeout && (pos_q >= chk_pos);

	assign mem_we    = in_xfer && !rx.timeout && (pos_q >= POS_W'(srfc_pkg::HDR_LEN))
		&& (pos_q < chk_pos);
	assign mem_waddr = IDX_W'(pos_q - POS_W'(srfc_pkg::HDR_LEN));
	assign rd_last   = (POS_W'(rd_idx_q) + POS_W'(1)) == n_eff;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q          <= srfc_pkg::EXPECTED_ID_RST;
			expected_param_count_q <= srfc_pkg::PARAM_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srfc_pkg::REG_EXPECTED_ID:          expected_id_q <= cfg_data;
				srfc_pkg::REG_EXPECTED_PARAM_COUNT:
					expected_param_count_q <= srfc_pkg::pcount_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Advance the frame position, sum and error flags; clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			running_sum_q <= '0;
			header_bad_q  <= 1'b0;
			id_bad_q      <= 1'b0;
		end else if (in_xfer) begin
			if (rx.timeout || is_chk) begin
				pos_q         <= '0;
				running_sum_q <= '0;
				header_bad_q  <= 1'b0;
				id_bad_q      <= 1'b0;
			end else if (pos_q < POS_W'(srfc_pkg::SYNC_LEN)) begin
				if (rx.rx_byte != srfc_pkg::HDR_BYTE) begin
					header_bad_q <= 1'b1;
				end
				pos_q <= pos_q + POS_W'(1);
			end else begin
				if ((pos_q == POS_W'(srfc_pkg::ID_POS)) && (rx.rx_byte != expected_id_q)) begin
					id_bad_q <= 1'b1;
				end
				running_sum_q <= running_sum_q + rx.rx_byte;
				pos_q         <= pos_q + POS_W'(1);
			end
		end
	end

	// Parameter memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			param_mem[mem_waddr] <= rx.rx_byte;
		end
		if (state_q == ST_READ) begin
			mem_rdata_q <= param_mem[rd_idx_q];
		end
	end

	// Pick the next result to load into the output register
	always_comb begin
		ld_en       = 1'b0;
		ld_byte     = '0;
		ld_idx      = '0;
		ld_status   = srfc_pkg::STATUS_OK;
		ld_last     = 1'b1;
		start_burst = 1'b0;
		if (state_q == ST_RUN && in_xfer) begin
			if (rx.timeout) begin
				ld_en     = 1'b1;
				ld_status = srfc_pkg::STATUS_SHORT;
			end else if (is_chk) begin
				ld_en = 1'b1;
				if (header_bad_q) begin
					ld_status = srfc_pkg::STATUS_BAD_HDR;
				end else if (id_bad_q) begin
					ld_status = srfc_pkg::STATUS_WRONG_ID;
				end else if (rx.rx_byte != srfc_pkg::byte_t'(~running_sum_q)) begin
					ld_status = srfc_pkg::STATUS_BAD_CHK;
				end else if (n_eff != '0) begin
					ld_en       = 1'b0;
					start_burst = 1'b1;
				end
			end
		end else if (state_q == ST_SEND && out_free) begin
			ld_en   = 1'b1;
			ld_byte = mem_rdata_q;
			ld_idx  = srfc_pkg::pidx_t'(rd_idx_q);
			ld_last = rd_last;
		end
	end

	// Sequence the parameter burst and hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_en) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (start_burst) begin
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= ST_RUN;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (ld_en) begin
			out_byte_q   <= ld_byte;
			out_idx_q    <= ld_idx;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.param_byte  = out_byte_q;
	assign result.param_index = out_idx_q;
	assign result.status      = out_status_q;
	assign result.last        = out_last_q;

endmodule

[tb/sv/tb.sv]
// Testbench for the servo reply frame checker: directed table, then random frames.
module tb;

	localparam int CLK_PERIOD   = 20;
	localparam int MAX_P        = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_ITEMS = 500;
	localparam int PRINT_CAP    = 200;

	typedef struct packed {
		srfc_pkg::byte_t   param_byte;
		srfc_pkg::pidx_t   param_index;
		srfc_pkg::status_t status;
		logic              last;
	} frame_result_t;

	typedef enum {ROW_RX, ROW_SET_ID, ROW_SET_COUNT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		srfc_pkg::byte_t   data;
		logic              timeout;
		logic              pinned;
		srfc_pkg::status_t status;
	} stim_row_t;

	typedef enum {FR_GOOD, FR_BAD_HDR, FR_WRONG_ID, FR_BAD_CHK, FR_TRUNC, FR_NOISE} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [srfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [srfc_pkg::CFG_DATA_W-1:0] cfg_data;

	srfc_rx_if     rx_ch ();
	srfc_result_if res_ch ();

	servo_reply_frame_checker #(.MAX_PARAMS(MAX_P)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted register contents and frame state
	srfc_pkg::byte_t   want_id;
	srfc_pkg::pcount_t want_count;
	int                fr_pos;
	srfc_pkg::byte_t   fr_sum;
	logic              fr_hdr_bad;
	logic              fr_id_bad;
	srfc_pkg::byte_t   fr_params [MAX_P];

	frame_result_t step_out[$];
	frame_result_t awaited_results[$];

	int mismatches    = 0;
	int items_sent    = 0;
	int src_idle_pct  = 19;
	int sink_idle_pct = 80;

	// Directed table: reset settings, timeout at the start, error priority, zero params
	stim_row_t dir_rows [35] = '{
		// reset settings: id 1, two params, params 00 and FF
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h01, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h04, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFB, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		// timeout with no byte of the frame received
		'{ROW_RX, 8'hA5, 1'b1, 1'b1, srfc_pkg::STATUS_SHORT},
		// top id, no params; upper nibble of the count write is dropped
		'{ROW_SET_ID,    8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_SET_COUNT, 8'hF0, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		// bad header wins over wrong id and checksum
		'{ROW_RX, 8'hFE, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h02, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b1, srfc_pkg::STATUS_BAD_HDR},
		// wrong id wins over checksum
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h02, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b1, srfc_pkg::STATUS_WRONG_ID},
		// checksum mismatch alone
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h02, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b1, srfc_pkg::STATUS_BAD_CHK},
		// zero params: a single ok result
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFF, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h02, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'h00, 1'b0, 1'b0, srfc_pkg::STATUS_OK},
		'{ROW_RX, 8'hFE, 1'b0, 1'b1, srfc_pkg::STATUS_OK}
	};

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic frame_result_t mk_result(srfc_pkg::byte_t b, srfc_pkg::pidx_t idx,
			srfc_pkg::status_t st, logic lst);
		frame_result_t r;
		r.param_byte  = b;
		r.param_index = idx;
		r.status      = st;
		r.last        = lst;
		return r;
	endfunction

	function automatic int clamped_count();
		return (int'(want_count) > MAX_P) ? MAX_P : int'(want_count);
	endfunction

	function automatic void frame_clear();
		fr_pos     = 0;
		fr_sum     = 8'h00;
		fr_hdr_bad = 1'b0;
		fr_id_bad  = 1'b0;
	endfunction

	// Advance the frame state by one transfer and collect the results it causes
	function automatic void frame_predict(srfc_pkg::byte_t b, logic to);
		int n;
		n = clamped_count();
		step_out.delete();
		if (to) begin
			step_out = {step_out, mk_result(8'h00, 3'd0, srfc_pkg::STATUS_SHORT, 1'b1)};
			frame_clear();
			return;
		end
		if (fr_pos < srfc_pkg::SYNC_LEN) begin
			if (b != srfc_pkg::HDR_BYTE)
				fr_hdr_bad = 1'b1;
		end else if (fr_pos < srfc_pkg::HDR_LEN + n) begin
			if (fr_pos == srfc_pkg::ID_POS && b != want_id)
				fr_id_bad = 1'b1;
			if (fr_pos >= srfc_pkg::HDR_LEN)
				fr_params[(fr_pos - srfc_pkg::HDR_LEN) % MAX_P] = b;
			fr_sum = fr_sum + b;
		end else begin
			if (fr_hdr_bad)
				step_out = {step_out,
					mk_result(8'h00, 3'd0, srfc_pkg::STATUS_BAD_HDR, 1'b1)};
			else if (fr_id_bad)
				step_out = {step_out,
					mk_result(8'h00, 3'd0, srfc_pkg::STATUS_WRONG_ID, 1'b1)};
			else if (srfc_pkg::byte_t'(~fr_sum) != b)
				step_out = {step_out,
					mk_result(8'h00, 3'd0, srfc_pkg::STATUS_BAD_CHK, 1'b1)};
			else if (n == 0)
				step_out = {step_out, mk_result(8'h00, 3'd0, srfc_pkg::STATUS_OK, 1'b1)};
			else
				for (int i = 0; i < n; i++)
					step_out = {step_out, mk_result(fr_params[i], srfc_pkg::pidx_t'(i),
						srfc_pkg::STATUS_OK, logic'(i == n - 1))};
			frame_clear();
			return;
		end
		fr_pos++;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s", $time, msg);
	endtask

	// Drive one rx item, wait for its transfer, then queue what it should cause
	task automatic push_byte(input srfc_pkg::byte_t b, input logic to,
			input logic pinned = 1'b0,
			input srfc_pkg::status_t pin_status = srfc_pkg::STATUS_OK);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.timeout <= to;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		frame_predict(b, to);
		if (pinned) begin
			step_out.delete();
			step_out = {step_out, mk_result(8'h00, 3'd0, pin_status, 1'b1)};
		end
		foreach (step_out[k])
			awaited_results = {awaited_results, step_out[k]};
		items_sent++;
	endtask

	// Drop valid, wait for every awaited result, then let the block drain
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [srfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [srfc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == srfc_pkg::REG_EXPECTED_ID)
			want_id = data;
		else
			want_count = data[3:0];
	endtask

	function automatic logic [srfc_pkg::CFG_DATA_W-1:0] pick_count_data();
		logic [3:0] c;
		case ($urandom_range(4))
			0: c = 4'd0;
			1: c = 4'd8;
			2: c = 4'd15;
			default: c = 4'($urandom_range(15));
		endcase
		return {4'($urandom), c};
	endfunction

	task automatic reconfigure();
		settle();
		case ($urandom_range(3))
			0: cfg_write(srfc_pkg::REG_EXPECTED_ID, 8'h00);
			1: cfg_write(srfc_pkg::REG_EXPECTED_ID, 8'hFF);
			default: cfg_write(srfc_pkg::REG_EXPECTED_ID, 8'($urandom));
		endcase
		cfg_write(srfc_pkg::REG_EXPECTED_PARAM_COUNT, pick_count_data());
	endtask

	// Change the count inside a frame, then finish the frame from the predicted state
	task automatic recount_mid_frame();
		int k;
		if (fr_pos != 0)
			push_byte(8'($urandom), 1'b1);
		k = $urandom_range(srfc_pkg::HDR_LEN + clamped_count(), 1);
		for (int i = 0; i < k; i++)
			push_byte((i < srfc_pkg::SYNC_LEN) ? srfc_pkg::HDR_BYTE
				: (i == srfc_pkg::ID_POS) ? want_id : 8'($urandom), 1'b0);
		settle();
		cfg_write(srfc_pkg::REG_EXPECTED_PARAM_COUNT, pick_count_data());
		while (fr_pos != 0) begin
			if (fr_pos >= srfc_pkg::HDR_LEN + clamped_count() && $urandom_range(4) != 0)
				push_byte(srfc_pkg::byte_t'(~fr_sum), 1'b0);
			else
				push_byte(8'($urandom), 1'b0);
		end
	endtask

	// Build one reply frame with random content, corrupt it as asked, and send it
	task automatic send_frame(input frame_kind_t kind);
		srfc_pkg::byte_t bytes[$];
		srfc_pkg::byte_t sum;
		int              n;
		int              cut;
		n = clamped_count();
		bytes = {bytes, srfc_pkg::HDR_BYTE};
		bytes = {bytes, srfc_pkg::HDR_BYTE};
		bytes = {bytes, want_id};
		bytes = {bytes, ($urandom_range(3) == 0) ? 8'($urandom) : 8'(n + 2)};
		bytes = {bytes, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom)};
		repeat (n) bytes = {bytes, 8'($urandom)};
		sum = 8'h00;
		for (int i = srfc_pkg::ID_POS; i < bytes.size(); i++)
			sum = sum + bytes[i];
		bytes = {bytes, ~sum};
		case (kind)
			FR_BAD_HDR: begin
				bytes[$urandom_range(1)] = 8'($urandom_range(254));
				if ($urandom_range(3) == 0)
					bytes[0] = 8'($urandom_range(254));
			end
			FR_WRONG_ID: bytes[srfc_pkg::ID_POS] = want_id ^ 8'($urandom_range(255, 1));
			FR_BAD_CHK: bytes[bytes.size() - 1] =
				bytes[bytes.size() - 1] ^ 8'($urandom_range(255, 1));
			default: ;
		endcase
		if (kind == FR_TRUNC) begin
			cut = $urandom_range(bytes.size() - 1);
			for (int i = 0; i < cut; i++)
				push_byte(bytes[i], 1'b0);
			push_byte(8'($urandom), 1'b1);
		end else if (kind == FR_NOISE) begin
			repeat ($urandom_range(8, 1)) push_byte(8'($urandom), 1'b0);
			if ($urandom_range(1) == 0)
				push_byte(8'($urandom), 1'b1);
		end else begin
			foreach (bytes[i])
				push_byte(bytes[i], 1'b0);
		end
	endtask

	// Stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Compare each result transfer with the oldest awaited result
	always @(posedge clk) begin : result_check
		frame_result_t got;
		frame_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = mk_result(res_ch.param_byte, res_ch.param_index, res_ch.status, res_ch.last);
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte=%02h idx=%0d st=%0d last=%0b",
					got.param_byte, got.param_index, got.status, got.last));
			end else begin
				want = awaited_results.pop_front();
				if (got.param_byte != want.param_byte || got.param_index != want.param_index ||
						got.status != want.status || got.last != want.last)
					report_mismatch($sformatf(
						"result byte=%02h idx=%0d st=%0d last=%0b, want %02h %0d %0d %0b",
						got.param_byte, got.param_index, got.status, got.last,
						want.param_byte, want.param_index, want.status, want.last));
			end
		end
	end

	// Hard limit on the run
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int base;
		int done;
		int next_cfg;
		int pick;
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		rx_ch.timeout <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= srfc_pkg::REG_EXPECTED_ID;
		cfg_data      <= 8'h00;
		want_id    = srfc_pkg::EXPECTED_ID_RST;
		want_count = srfc_pkg::PARAM_COUNT_RST;
		frame_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_SET_ID: begin
					settle();
					cfg_write(srfc_pkg::REG_EXPECTED_ID, dir_rows[r].data);
				end
				ROW_SET_COUNT: begin
					settle();
					cfg_write(srfc_pkg::REG_EXPECTED_PARAM_COUNT, dir_rows[r].data);
				end
				default: push_byte(dir_rows[r].data, dir_rows[r].timeout, dir_rows[r].pinned,
					dir_rows[r].status);
			endcase
		end

		// Random frames, mostly well formed, over three idling phases
		base     = items_sent;
		next_cfg = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			done = items_sent - base;
			if (done < RANDOM_ITEMS / 3) begin
				src_idle_pct  = 19;
				sink_idle_pct = 80;
			end else if (done < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct  = 80;
				sink_idle_pct = 19;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			if (done >= next_cfg) begin
				if (done == 0) begin
					// lowest id and a count above the buffer size
					settle();
					cfg_write(srfc_pkg::REG_EXPECTED_ID, 8'h00);
					cfg_write(srfc_pkg::REG_EXPECTED_PARAM_COUNT, 8'h0F);
				end else if ($urandom_range(3) == 0) begin
					recount_mid_frame();
				end else begin
					reconfigure();
				end
				next_cfg = items_sent - base + $urandom_range(80, 30);
			end
			pick = $urandom_range(99);
			if (pick < 68)
				send_frame(FR_GOOD);
			else if (pick < 74)
				send_frame(FR_BAD_HDR);
			else if (pick < 80)
				send_frame(FR_WRONG_ID);
			else if (pick < 88)
				send_frame(FR_BAD_CHK);
			else if (pick < 95)
				send_frame(FR_TRUNC);
			else
				send_frame(FR_NOISE);
		end

		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
hdl/srfc_pkg.sv
hdl/srfc_if.sv
hdl/servo_reply_frame_checker.sv
tb/sv/tb.sv
